/* design/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

/* design/mpg_pkg.sv */
package mpg_pkg;

   localparam int CHANNELS_DEFAULT = 8;
   localparam int OUT_W = 8;
   localparam int RATE_W = 16;
   localparam int TIME_W = 32;
   localparam int HP_W = 19;
   localparam int CNT_DIV_W = 5;
   localparam logic [HP_W-1:0] HALF_NUM = 19'd500000;

   localparam logic OP_SET = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_RUN = 2'd1,
      MODE_STOP = 2'd2
   } mode_type;

   typedef struct packed {
      logic opcode;
      logic [7:0] channel;
      logic [RATE_W-1:0] rate;
      logic [TIME_W-1:0] current_time;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] levels;
      logic [OUT_W-1:0] toggled;
   } rsp_type;

   typedef struct packed {
      logic [HP_W-1:0] half_period;
      logic [TIME_W-1:0] next_edge_time;
   } entry_type;

   typedef struct packed {
      logic start;
      logic [RATE_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic [HP_W-1:0] quotient;
   } div_rsp_type;

endpackage

/* design/mpg_div.sv */
module mpg_div (
   input logic clock,
   input logic reset,
   input mpg_pkg::div_req_type div_req,
   output mpg_pkg::div_rsp_type div_rsp
);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [mpg_pkg::CNT_DIV_W-1:0] cnt_ff, cnt_in;
   logic [mpg_pkg::RATE_W-1:0] rem_ff, rem_in;
   logic [mpg_pkg::RATE_W-1:0] dvs_ff, dvs_in;
   logic [mpg_pkg::HP_W-1:0] quo_ff, quo_in;
   logic [mpg_pkg::RATE_W:0] rem_sh;
   logic [mpg_pkg::RATE_W:0] diff;

   // restoring division of the fixed numerator, one quotient bit a cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      quo_in = quo_ff;
      rem_sh = {rem_ff, mpg_pkg::HALF_NUM[cnt_ff]};
      diff = rem_sh - {1'b0, dvs_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in = mpg_pkg::CNT_DIV_W'(mpg_pkg::HP_W - 1);
         rem_in = '0;
         dvs_in = div_req.divisor;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = diff[mpg_pkg::RATE_W-1:0];
            quo_in = {quo_ff[mpg_pkg::HP_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[mpg_pkg::RATE_W-1:0];
            quo_in = {quo_ff[mpg_pkg::HP_W-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

/* design/mpg_mem.sv */
module mpg_mem #(
   parameter int DEPTH = mpg_pkg::CHANNELS_DEFAULT,
   parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input logic clock,
   input logic wr_en,
   input logic [IDX_W-1:0] wr_addr,
   input mpg_pkg::entry_type wr_data,
   input logic rd_en,
   input logic [IDX_W-1:0] rd_addr,
   output mpg_pkg::entry_type rd_data
);

   mpg_pkg::entry_type mem [DEPTH];
   mpg_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/multichannel_pulse_generator_top.sv */
// Square-wave generator for up to CHANNELS channels, one request at a time. A set request with
// a nonzero rate starts a bit-serial divider for the half period while the channel entry is
// read, then does a subtract and a write of the channel entry. A set with rate 0 or an
// out-of-range channel goes straight to the done state. A tick request walks the channel
// memory one entry a cycle through its single read and write port. The
// response sits in an output register, so a new request is taken while it waits. Half period
// and next edge time live in a memory; run mode and level are flip-flops cleared by reset.
`include "assert_macros.svh"

module multichannel_pulse_generator_top #(
   parameter int CHANNELS = mpg_pkg::CHANNELS_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input mpg_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output mpg_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W = $clog2(CHANNELS + 1);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_DIV = 6'b000010,
      ST_BASE = 6'b000100,
      ST_SET = 6'b001000,
      ST_WALK = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   mpg_pkg::req_type req_ff, req_in;
   mpg_pkg::mode_type [CHANNELS-1:0] mode_ff, mode_in;
   logic [CHANNELS-1:0] level_ff, level_in;
   logic [CHANNELS-1:0] toggle_ff, toggle_in;
   logic [mpg_pkg::TIME_W-1:0] base_ff, base_in;
   logic [CNT_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic proc_valid_ff, proc_valid_in;
   logic [IDX_W-1:0] proc_idx_ff, proc_idx_in;
   logic rsp_valid_ff, rsp_valid_in;
   mpg_pkg::rsp_type rsp_ff, rsp_in;

   mpg_pkg::div_req_type div_req;
   mpg_pkg::div_rsp_type div_rsp;

   logic mem_we;
   logic [IDX_W-1:0] mem_waddr;
   mpg_pkg::entry_type mem_wdata;
   logic mem_re;
   logic [IDX_W-1:0] mem_raddr;
   mpg_pkg::entry_type mem_rdata;

   logic [mpg_pkg::OUT_W-1:0] levels_out;
   logic [mpg_pkg::OUT_W-1:0] toggles_out;
   logic req_accept;
   logic req_in_range;
   logic [IDX_W-1:0] req_idx;
   logic [IDX_W-1:0] ch_idx;
   logic [mpg_pkg::TIME_W-1:0] delta_ext;
   logic [mpg_pkg::TIME_W-1:0] t_new;
   logic [mpg_pkg::TIME_W-1:0] edge_adv;

   mpg_div u_div (
      .clock(clock),
      .reset(reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   mpg_mem #(
      .DEPTH(CHANNELS),
      .IDX_W(IDX_W)
   ) u_mem (
      .clock(clock),
      .wr_en(mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_en(mem_re),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   // only the low channels reach the 8-bit response fields
   for (genvar i = 0; i < mpg_pkg::OUT_W; i++) begin : g_out
      if (i < CHANNELS) begin : g_on
         assign levels_out[i] = level_ff[i];
         assign toggles_out[i] = toggle_ff[i];
      end else begin : g_off
         assign levels_out[i] = 1'b0;
         assign toggles_out[i] = 1'b0;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign req_in_range = (req_data.channel < 8'(CHANNELS));
   assign req_idx = req_data.channel[IDX_W-1:0];
   assign ch_idx = req_ff.channel[IDX_W-1:0];
   assign delta_ext = {{(mpg_pkg::TIME_W - mpg_pkg::HP_W){1'b0}}, div_rsp.quotient};
   assign t_new = base_ff + delta_ext;
   assign edge_adv = mem_rdata.next_edge_time
      + {{(mpg_pkg::TIME_W - mpg_pkg::HP_W){1'b0}}, mem_rdata.half_period};

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      mode_in = mode_ff;
      level_in = level_ff;
      toggle_in = toggle_ff;
      base_in = base_ff;
      rd_cnt_in = rd_cnt_ff;
      proc_valid_in = 1'b0;
      proc_idx_in = proc_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      div_req.start = 1'b0;
      div_req.divisor = req_data.rate;
      mem_we = 1'b0;
      mem_waddr = ch_idx;
      mem_wdata = mem_rdata;
      mem_re = 1'b0;
      mem_raddr = req_idx;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               req_in = req_data;
               toggle_in = '0;
               if (req_data.opcode == mpg_pkg::OP_TICK) begin
                  rd_cnt_in = '0;
                  state_in = ST_WALK;
               end else if (!req_in_range) begin
                  state_in = ST_DONE;
               end else if (req_data.rate == '0) begin
                  // stop holds the level; a never-started channel stays idle
                  if (mode_ff[req_idx] != mpg_pkg::MODE_IDLE) begin
                     mode_in[req_idx] = mpg_pkg::MODE_STOP;
                  end
                  state_in = ST_DONE;
               end else begin
                  div_req.start = 1'b1;
                  mem_re = 1'b1;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            // last edge time, so the phase survives a rate change
            base_in = mem_rdata.next_edge_time
               - {{(mpg_pkg::TIME_W - mpg_pkg::HP_W){1'b0}}, mem_rdata.half_period};
            state_in = ST_SET;
         end
         ST_SET: begin
            mem_we = 1'b1;
            mem_wdata.half_period = div_rsp.quotient;
            if (mode_ff[ch_idx] == mpg_pkg::MODE_IDLE) begin
               mem_wdata.next_edge_time = req_ff.current_time + delta_ext;
               level_in[ch_idx] = 1'b1;
               toggle_in[ch_idx] = !level_ff[ch_idx];
            end else if (t_new < req_ff.current_time) begin
               mem_wdata.next_edge_time = req_ff.current_time;
            end else begin
               mem_wdata.next_edge_time = t_new;
            end
            mode_in[ch_idx] = mpg_pkg::MODE_RUN;
            state_in = ST_DONE;
         end
         ST_WALK: begin
            // read entry n while entry n-1 is checked and written back
            if (rd_cnt_ff < CNT_W'(CHANNELS)) begin
               mem_re = 1'b1;
               mem_raddr = rd_cnt_ff[IDX_W-1:0];
               proc_valid_in = 1'b1;
               proc_idx_in = rd_cnt_ff[IDX_W-1:0];
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end else if (!proc_valid_ff) begin
               state_in = ST_DONE;
            end
            mem_waddr = proc_idx_ff;
            if (proc_valid_ff && mode_ff[proc_idx_ff] == mpg_pkg::MODE_RUN
                  && req_ff.current_time >= mem_rdata.next_edge_time) begin
               mem_we = 1'b1;
               mem_wdata.next_edge_time = edge_adv;
               level_in[proc_idx_ff] = !level_ff[proc_idx_ff];
               toggle_in[proc_idx_ff] = 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in.levels = levels_out;
               rsp_in.toggled = toggles_out;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff <= {CHANNELS{mpg_pkg::MODE_IDLE}};
         level_ff <= '0;
         proc_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff <= mode_in;
         level_ff <= level_in;
         proc_valid_ff <= proc_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      toggle_ff <= toggle_in;
      base_ff <= base_in;
      rd_cnt_ff <= rd_cnt_in;
      proc_idx_ff <= proc_idx_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `ASSERT_CLK(a_div_done_in_div, clock, reset,
      div_rsp.done |-> state_ff == ST_DIV, "divider finished outside the divide wait")
   `ASSERT_CLK(a_mem_write_state, clock, reset,
      mem_we |-> (state_ff == ST_SET || state_ff == ST_WALK), "memory write in wrong state")
   `ASSERT_CLK(a_rsp_from_done, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE), "response loaded outside done")
   `ASSERT_NEVER(a_proc_outside_walk, clock, reset,
      proc_valid_ff && state_ff != ST_WALK, "channel check pending outside the walk")
   `ASSERT_NEVER(a_div_start_busy, clock, reset,
      div_req.start && div_rsp.busy, "divider started while busy")

endmodule

/* bench/tb_multichannel_pulse_generator_top.sv */
module tb_multichannel_pulse_generator_top;

   localparam int NCH = mpg_pkg::CHANNELS_DEFAULT;
   localparam int RANDOM_ITEMS = 430;
   localparam int TAIL_ITEMS = 50;

   typedef struct packed {
      mpg_pkg::req_type req;
      logic fixed;
      mpg_pkg::rsp_type rsp;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   mpg_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   mpg_pkg::rsp_type rsp_data;

   // predicted channel state
   logic [mpg_pkg::HP_W-1:0] half_period_m [NCH];
   logic [mpg_pkg::TIME_W-1:0] next_edge_m [NCH];
   mpg_pkg::mode_type mode_m [NCH];
   logic [NCH-1:0] level_m;

   script_row_type pulse_script_q [$];
   mpg_pkg::rsp_type expected_levels_q [$];
   mpg_pkg::rsp_type expected_rsp;
   int error_count = 0;
   int accepted_count = 0;
   int stall_left = 0;
   logic quiet_tail = 1'b0;
   logic hold_rsp = 1'b0;

   multichannel_pulse_generator_top u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   function automatic mpg_pkg::rsp_type step_pulses(input mpg_pkg::req_type r);
      mpg_pkg::rsp_type res;
      logic [mpg_pkg::HP_W-1:0] delta;
      logic [mpg_pkg::TIME_W-1:0] t;
      int ch;
      res.toggled = '0;
      if (r.opcode == mpg_pkg::OP_SET) begin
         if (r.channel < 8'(NCH)) begin
            ch = int'(r.channel);
            if (r.rate == '0) begin
               // stop holds the level; ignored on a channel never started
               if (mode_m[ch] != mpg_pkg::MODE_IDLE) mode_m[ch] = mpg_pkg::MODE_STOP;
            end else begin
               delta = mpg_pkg::HALF_NUM / mpg_pkg::HP_W'(r.rate);
               if (mode_m[ch] == mpg_pkg::MODE_IDLE) begin
                  if (!level_m[ch]) res.toggled[ch] = 1'b1;
                  half_period_m[ch] = delta;
                  next_edge_m[ch] = r.current_time + mpg_pkg::TIME_W'(delta);
                  level_m[ch] = 1'b1;
               end else begin
                  // keep the last edge, clamp the next one to now
                  t = next_edge_m[ch] - mpg_pkg::TIME_W'(half_period_m[ch])
                     + mpg_pkg::TIME_W'(delta);
                  half_period_m[ch] = delta;
                  if (t < r.current_time) t = r.current_time;
                  next_edge_m[ch] = t;
               end
               mode_m[ch] = mpg_pkg::MODE_RUN;
            end
         end
      end else begin
         for (int n = 0; n < NCH; n++) begin
            if (mode_m[n] == mpg_pkg::MODE_RUN && r.current_time >= next_edge_m[n]) begin
               next_edge_m[n] = next_edge_m[n] + mpg_pkg::TIME_W'(half_period_m[n]);
               level_m[n] = ~level_m[n];
               res.toggled[n] = 1'b1;
            end
         end
      end
      res.levels = level_m[mpg_pkg::OUT_W-1:0];
      return res;
   endfunction

   function automatic void add_row(input logic op, input logic [7:0] ch,
                                   input logic [mpg_pkg::RATE_W-1:0] rate,
                                   input logic [mpg_pkg::TIME_W-1:0] t, input logic fixed,
                                   input logic [mpg_pkg::OUT_W-1:0] lv,
                                   input logic [mpg_pkg::OUT_W-1:0] tg);
      script_row_type row;
      row.req.opcode = op;
      row.req.channel = ch;
      row.req.rate = rate;
      row.req.current_time = t;
      row.fixed = fixed;
      row.rsp.levels = lv;
      row.rsp.toggled = tg;
      pulse_script_q.push_back(row);
   endfunction

   task automatic send_request(input mpg_pkg::req_type r, input logic fixed,
                               input mpg_pkg::rsp_type typed);
      int gap;
      mpg_pkg::rsp_type predicted;
      gap = 0;
      if (!quiet_tail && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 10);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = step_pulses(r);
      expected_levels_q.push_back(fixed ? typed : predicted);
      accepted_count++;
   endtask

   // response side: check, then pick the stall for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_levels_q.size() == 0) begin
            $display("%0t: response with no request pending, actual %h", $time, rsp_data);
            error_count++;
         end else begin
            expected_rsp = expected_levels_q.pop_front();
            if (rsp_data.levels !== expected_rsp.levels) begin
               $display("%0t: levels mismatch, expected %h actual %h",
                        $time, expected_rsp.levels, rsp_data.levels);
               error_count++;
            end
            if (rsp_data.toggled !== expected_rsp.toggled) begin
               $display("%0t: toggled mismatch, expected %h actual %h",
                        $time, expected_rsp.toggled, rsp_data.toggled);
               error_count++;
            end
         end
      end
      if (hold_rsp) begin
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 9);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // long hold-off on the response side so the block backs up into the request side
   initial begin
      wait (accepted_count >= 120);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (300) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      #5000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      mpg_pkg::req_type r;
      mpg_pkg::rsp_type none;
      logic [mpg_pkg::TIME_W-1:0] now_us;
      int pick;
      none = '0;
      for (int n = 0; n < NCH; n++) begin
         half_period_m[n] = '0;
         next_edge_m[n] = '0;
         mode_m[n] = mpg_pkg::MODE_IDLE;
      end
      level_m = '0;

      // after reset, out of range, stop before start, first starts
      add_row(mpg_pkg::OP_TICK, 8'd0, 16'd0, 32'd0, 1'b1, 8'h00, 8'h00);
      add_row(mpg_pkg::OP_SET, 8'd255, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 8'h00, 8'h00);
      add_row(mpg_pkg::OP_SET, 8'd8, 16'd1, 32'd0, 1'b1, 8'h00, 8'h00);
      add_row(mpg_pkg::OP_SET, 8'd3, 16'd0, 32'd100, 1'b1, 8'h00, 8'h00);
      add_row(mpg_pkg::OP_SET, 8'd0, 16'hFFFF, 32'd0, 1'b1, 8'h01, 8'h01);
      add_row(mpg_pkg::OP_SET, 8'd7, 16'd1, 32'hFFFF_FFF0, 1'b1, 8'h81, 8'h80);
      // edge timing, stop, restart, phase kept on rate change
      add_row(mpg_pkg::OP_TICK, 8'd0, 16'd0, 32'd6, 1'b0, 8'h00, 8'h00);
      add_row(mpg_pkg::OP_TICK, 8'd0, 16'd0, 32'd7, 1'b0, 8'h00, 8'h00);
      add_row(mpg_pkg::OP_SET, 8'd0, 16'd0, 32'd50, 1'b0, 8'h00, 8'h00);
      add_row(mpg_pkg::OP_TICK, 8'd0, 16'd0, 32'd1000, 1'b0, 8'h00, 8'h00);
      add_row(mpg_pkg::OP_SET, 8'd0, 16'd1000, 32'd2000, 1'b0, 8'h00, 8'h00);
      add_row(mpg_pkg::OP_SET, 8'd3, 16'd250, 32'd2000, 1'b0, 8'h00, 8'h00);
      add_row(mpg_pkg::OP_SET, 8'd3, 16'd500, 32'd2100, 1'b0, 8'h00, 8'h00);
      add_row(mpg_pkg::OP_TICK, 8'd0, 16'd0, 32'd3000, 1'b0, 8'h00, 8'h00);
      add_row(mpg_pkg::OP_SET, 8'd1, 16'd7, 32'd3000, 1'b0, 8'h00, 8'h00);
      // a set past the edge must not tick
      add_row(mpg_pkg::OP_SET, 8'd0, 16'hFFFF, 32'd100000, 1'b0, 8'h00, 8'h00);
      // time extremes and wrapping edges
      add_row(mpg_pkg::OP_TICK, 8'd0, 16'd0, 32'hFFFF_FFFF, 1'b0, 8'h00, 8'h00);
      add_row(mpg_pkg::OP_TICK, 8'd0, 16'd0, 32'd0, 1'b0, 8'h00, 8'h00);
      add_row(mpg_pkg::OP_SET, 8'd5, 16'd3, 32'hFFFF_0000, 1'b0, 8'h00, 8'h00);
      add_row(mpg_pkg::OP_SET, 8'd2, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 8'h00, 8'h00);
      add_row(mpg_pkg::OP_TICK, 8'd0, 16'd0, 32'hFFFF_FFFF, 1'b0, 8'h00, 8'h00);
      add_row(mpg_pkg::OP_SET, 8'd6, 16'hAAAA, 32'h5555_5555, 1'b0, 8'h00, 8'h00);
      add_row(mpg_pkg::OP_SET, 8'd4, 16'h5555, 32'hAAAA_AAAA, 1'b0, 8'h00, 8'h00);
      add_row(mpg_pkg::OP_TICK, 8'd0, 16'd0, 32'hAAAA_AAAA, 1'b0, 8'h00, 8'h00);

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (pulse_script_q[i])
         send_request(pulse_script_q[i].req, pulse_script_q[i].fixed, pulse_script_q[i].rsp);

      now_us = $urandom_range(0, 100000);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i >= RANDOM_ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
         pick = $urandom_range(0, 99);
         r = '0;
         if (pick < 55) begin
            now_us = now_us + $urandom_range(0, 1500);
            r.opcode = mpg_pkg::OP_TICK;
            r.channel = 8'($urandom_range(0, 255));
            r.rate = 16'($urandom_range(0, 65535));
            r.current_time = now_us;
         end else if (pick < 85) begin
            r.opcode = mpg_pkg::OP_SET;
            r.channel = 8'($urandom_range(0, NCH - 1));
            case ($urandom_range(0, 9))
               0: r.rate = '0;
               1, 2: r.rate = 16'($urandom_range(1, 249));
               default: r.rate = 16'($urandom_range(250, 65535));
            endcase
            r.current_time = now_us;
         end else if (pick < 93) begin
            // noise: channel beyond the last one, arbitrary time
            r.opcode = mpg_pkg::OP_SET;
            r.channel = 8'($urandom_range(NCH, 255));
            r.rate = 16'($urandom_range(0, 65535));
            r.current_time = $urandom();
         end else begin
            // time jump, sometimes just short of the wrap
            if ($urandom_range(0, 1) == 0) now_us = $urandom();
            else now_us = 32'hFFFF_F000 + $urandom_range(0, 4095);
            r.opcode = mpg_pkg::OP_TICK;
            r.channel = 8'($urandom_range(0, 255));
            r.rate = 16'($urandom_range(0, 65535));
            r.current_time = now_us;
         end
         send_request(r, 1'b0, none);
      end
      req_valid <= 1'b0;

      while (expected_levels_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
